// File: rtl/core/fmrc_pkg.sv
// Shared types, constants and helpers of the first-match flow rule classifier.
package fmrc_pkg;

  localparam int RULES_PER_ROLE = 32;
  localparam int NUM_ROLES      = 5;
  localparam int NUM_RULES      = NUM_ROLES * RULES_PER_ROLE;
  localparam int ADDR_W         = $clog2(NUM_RULES);
  localparam int CNT_W          = $clog2(RULES_PER_ROLE + 1);
  localparam int CTL_W          = 26;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] TR_OS      = 2'd0;
  localparam logic [1:0] TR_DEFAULT = 2'd1;
  localparam logic [1:0] TR_ULP     = 2'd2;

  localparam logic [2:0] ROLE_TCP_ACTIVE = 3'd1;
  localparam logic [2:0] ROLE_UDP_PEER   = 3'd4;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;

  localparam logic [1:0] WSEL_EP1 = 2'd0;
  localparam logic [1:0] WSEL_EP2 = 2'd1;
  localparam logic [1:0] WSEL_CTL = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  role;
    logic [4:0]  rule_slot;
    logic [1:0]  word_select;
    logic [63:0] write_data;
    logic [1:0]  own_transport;
    logic [31:0] first_addr;
    logic [15:0] first_port;
    logic        first_addr_ok;
    logic [1:0]  second_kind;
    logic [31:0] second_addr;
    logic [15:0] second_port;
  } fmrc_in_t;

  typedef struct packed {
    logic [1:0] chosen_transport;
    logic       matched;
    logic [4:0] matched_slot;
  } fmrc_out_t;

  // Control from the sequencer to the rule store
  typedef struct packed {
    logic              we;
    logic              re;
    logic [1:0]        wsel;
    logic [ADDR_W-1:0] addr;
  } store_cmd_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] tgt;
  } match_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_FETCH,
    ST_SCAN,
    ST_DONE
  } fmrc_state_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len >= 6'd32) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = ~(32'hFFFF_FFFF >> len);
    end
    return m;
  endfunction

  function automatic logic [ADDR_W-1:0] rule_addr(input logic [2:0] role,
                                                  input logic [CNT_W-1:0] slot);
    logic [ADDR_W+8:0] a;
    a = (ADDR_W+9)'(role) * (ADDR_W+9)'(RULES_PER_ROLE) + (ADDR_W+9)'(slot);
    return a[ADDR_W-1:0];
  endfunction

endpackage

// File: rtl/core/fmrc_rule_store.sv
// Rule memories (two endpoint words, one control word) and rule valid bits.
module fmrc_rule_store
  import fmrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  store_cmd_t       cmd,
  input  logic [63:0]      wdata,
  output logic [63:0]      ep1_q,
  output logic [63:0]      ep2_q,
  output logic [CTL_W-1:0] ctl_q,
  output logic             valid_q
);

  logic [63:0]      ep1_mem [NUM_RULES];
  logic [63:0]      ep2_mem [NUM_RULES];
  logic [CTL_W-1:0] ctl_mem [NUM_RULES];
  logic             valid_r [NUM_RULES];

  logic [63:0]      ep1_q_r;
  logic [63:0]      ep2_q_r;
  logic [CTL_W-1:0] ctl_q_r;
  logic             valid_q_r;

  always_ff @(posedge clk) begin
    if (cmd.we && cmd.wsel == WSEL_EP1) begin
      ep1_mem[cmd.addr] <= wdata;
    end
    if (cmd.re) begin
      ep1_q_r <= ep1_mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.we && cmd.wsel == WSEL_EP2) begin
      ep2_mem[cmd.addr] <= wdata;
    end
    if (cmd.re) begin
      ep2_q_r <= ep2_mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.we && cmd.wsel == WSEL_CTL) begin
      ctl_mem[cmd.addr] <= wdata[CTL_W-1:0];
    end
    if (cmd.re) begin
      ctl_q_r <= ctl_mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_RULES; i++) begin
        valid_r[i] <= 1'b0;
      end
      valid_q_r <= 1'b0;
    end else begin
      if (cmd.we && cmd.wsel == WSEL_CTL) begin
        valid_r[cmd.addr] <= wdata[32];
      end
      if (cmd.re) begin
        valid_q_r <= valid_r[cmd.addr];
      end
    end
  end

  assign ep1_q   = ep1_q_r;
  assign ep2_q   = ep2_q_r;
  assign ctl_q   = ctl_q_r;
  assign valid_q = valid_q_r;

endmodule

// File: rtl/core/fmrc_match_unit.sv
// Compare unit: checks one fetched rule against the request's endpoints.
module fmrc_match_unit
  import fmrc_pkg::*;
(
  input  fmrc_in_t         req,
  input  logic [63:0]      ep1,
  input  logic [63:0]      ep2,
  input  logic [CTL_W-1:0] ctl,
  input  logic             rule_valid,
  output match_res_t       res
);

  logic [31:0] mask1;
  logic [31:0] mask2;
  logic        ok1;
  logic        ok2;
  logic        has_second;
  logic        second_conv;
  logic        tgt_ok;
  logic [1:0]  tgt;

  assign tgt = ctl[25:24];

  always_comb begin
    mask1 = prefix_mask(ctl[5:0]);
    mask2 = prefix_mask(ctl[13:8]);

    // Only tcp client and udp connect look at the second endpoint
    has_second  = (req.role == ROLE_TCP_ACTIVE || req.role == ROLE_UDP_PEER) &&
                  (req.second_kind != KIND_NONE);
    second_conv = (req.second_kind == KIND_OK);

    ok1 = 1'b1;
    if (ctl[16] && (req.first_port < ep1[47:32] || req.first_port > ep1[63:48])) begin
      ok1 = 1'b0;
    end
    if (ctl[17] && (!req.first_addr_ok ||
                    ((ep1[31:0] & mask1) != (req.first_addr & mask1)))) begin
      ok1 = 1'b0;
    end

    ok2 = 1'b1;
    if (ctl[18] && has_second) begin
      if (ctl[19] && (req.second_port < ep2[47:32] || req.second_port > ep2[63:48])) begin
        ok2 = 1'b0;
      end
      if (ctl[20] && (!second_conv ||
                      ((ep2[31:0] & mask2) != (req.second_addr & mask2)))) begin
        ok2 = 1'b0;
      end
    end

    tgt_ok = (tgt == TR_OS) || (tgt == TR_ULP) || (tgt == req.own_transport);

    res.hit = rule_valid && ok1 && ok2 && tgt_ok;
    res.tgt = tgt;
  end

endmodule

// File: rtl/core/first_match_flow_rule_classifier.sv
// Top level: request sequencer, rule store, compare unit and result register.
//
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------------
//  in      | in_valid, in_stall, in_data    | write of one rule word, or a lookup
//  out     | out_valid, out_stall, out_data | one result per request
//
// A write request goes from acceptance through the write state to the done state.
// A lookup fetches slot 0, then scans the role's list until the first hit or the
// last of its RULES_PER_ROLE slots: the compare unit sees one rule a cycle from the
// single read port of the rule memories. A lookup with a bad role goes straight to done.
// Reset clears all rule valid bits at once; the rule words themselves are not cleared.
// One request at a time; a result waiting under out_stall does not hold off the next
// request once it has been moved to the output register.
module first_match_flow_rule_classifier
  import fmrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  fmrc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output fmrc_out_t out_data
);

  fmrc_state_t state_r, state_nxt;

  fmrc_in_t         req_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       res_tr_r, res_tr_nxt;
  logic             res_m_r, res_m_nxt;
  logic [4:0]       res_slot_r, res_slot_nxt;
  logic             out_valid_r, out_valid_nxt;
  fmrc_out_t        out_data_r;

  store_cmd_t       st_cmd;
  logic [63:0]      ep1_q;
  logic [63:0]      ep2_q;
  logic [CTL_W-1:0] ctl_q;
  logic             valid_q;
  match_res_t       mres;

  logic             acc;
  logic             out_free;
  logic             load_out;
  logic             role_ok;
  logic             write_ok;
  logic             last_slot;

  assign acc       = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign role_ok   = in_data.role < 3'(NUM_ROLES);
  assign last_slot = (cnt_r == CNT_W'(RULES_PER_ROLE - 1));
  assign write_ok  = (req_r.role < 3'(NUM_ROLES)) &&
                     (32'(req_r.rule_slot) < 32'(RULES_PER_ROLE)) &&
                     (req_r.word_select inside {WSEL_EP1, WSEL_EP2, WSEL_CTL});

  fmrc_rule_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (st_cmd),
    .wdata   (req_r.write_data),
    .ep1_q   (ep1_q),
    .ep2_q   (ep2_q),
    .ctl_q   (ctl_q),
    .valid_q (valid_q)
  );

  fmrc_match_unit u_match (
    .req        (req_r),
    .ep1        (ep1_q),
    .ep2        (ep2_q),
    .ctl        (ctl_q),
    .rule_valid (valid_q),
    .res        (mres)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_data.cmd == CMD_WRITE) begin
            state_nxt = ST_WRITE;
          end else if (role_ok) begin
            state_nxt = ST_FETCH;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_WRITE: state_nxt = ST_DONE;
      ST_FETCH: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (mres.hit || last_slot) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall     = 1'b1;
    load_out     = 1'b0;
    st_cmd.we    = 1'b0;
    st_cmd.re    = 1'b0;
    st_cmd.wsel  = req_r.word_select;
    st_cmd.addr  = rule_addr(req_r.role, CNT_W'(req_r.rule_slot));
    cnt_nxt      = cnt_r;
    res_tr_nxt   = res_tr_r;
    res_m_nxt    = res_m_r;
    res_slot_nxt = res_slot_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (acc) begin
          cnt_nxt      = '0;
          res_tr_nxt   = (in_data.cmd == CMD_LOOKUP) ? TR_DEFAULT : TR_OS;
          res_m_nxt    = 1'b0;
          res_slot_nxt = '0;
        end
      end
      ST_WRITE: begin
        st_cmd.we = write_ok;
      end
      ST_FETCH: begin
        st_cmd.re   = 1'b1;
        st_cmd.addr = rule_addr(req_r.role, '0);
      end
      ST_SCAN: begin
        // Prefetch the next slot while comparing this one
        st_cmd.re   = !last_slot;
        st_cmd.addr = rule_addr(req_r.role, cnt_r + CNT_W'(1));
        cnt_nxt     = cnt_r + CNT_W'(1);
        if (mres.hit) begin
          res_tr_nxt   = mres.tgt;
          res_m_nxt    = 1'b1;
          res_slot_nxt = 5'(cnt_r);
        end
      end
      ST_DONE: begin
        load_out = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      req_r <= in_data;
    end
    res_tr_r   <= res_tr_nxt;
    res_m_r    <= res_m_nxt;
    res_slot_r <= res_slot_nxt;
    if (load_out) begin
      out_data_r.chosen_transport <= res_tr_r;
      out_data_r.matched          <= res_m_r;
      out_data_r.matched_slot     <= res_slot_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != ST_IDLE)
    else $error("accepted request did not start the sequencer");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result presented without finishing a request");

  a_unmatched_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.matched |-> out_data.matched_slot == 5'd0)
    else $error("unmatched result carries a slot");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> 32'(cnt_r) < 32'(RULES_PER_ROLE))
    else $error("scan ran past the end of the list");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench of the first-match flow rule classifier.
`timescale 1ns / 100ps

module testbench;
  import fmrc_pkg::*;

  localparam logic [1:0] TR_OTHER      = 2'd3;
  localparam logic [2:0] ROLE_TCP_SRV  = 3'd0;
  localparam logic [2:0] ROLE_MAX_CODE = 3'd7;
  localparam logic [1:0] WSEL_BAD      = 2'd3;
  localparam logic [1:0] KIND_BROKEN   = 2'd2;
  localparam logic [1:0] KIND_SPARE    = 2'd3;

  localparam int RULE_WORDS   = 3;
  localparam int CTL_PORT1_EN = 16;
  localparam int CTL_PFX1_EN  = 17;
  localparam int CTL_USE2     = 18;
  localparam int CTL_PORT2_EN = 19;
  localparam int CTL_PFX2_EN  = 20;
  localparam int CTL_VALID    = 32;

  localparam int ITEM_TARGET  = 1150;
  localparam int MAX_IDLE     = 6;
  localparam int TAIL_CYCLES  = 50;

  localparam fmrc_out_t WRITE_ACK = '{chosen_transport: TR_OS, matched: 1'b0,
                                      matched_slot: 5'd0};
  localparam fmrc_out_t NO_MATCH  = '{chosen_transport: TR_DEFAULT, matched: 1'b0,
                                      matched_slot: 5'd0};

  typedef struct packed {
    fmrc_in_t  req;
    logic      typed;
    fmrc_out_t want;
  } step_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  fmrc_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  fmrc_out_t out_data;

  // Predictor state
  logic [63:0] rule_mem  [NUM_RULES*RULE_WORDS] = '{default: '0};
  logic        word_seen [NUM_RULES*RULE_WORDS] = '{default: 1'b0};
  logic        rule_on   [NUM_RULES]            = '{default: 1'b0};

  fmrc_out_t   pending_results[$];
  step_t       plan[$];
  int          useful_items = 0;
  int          error_count  = 0;
  bit          idle_on      = 1'b1;
  int unsigned stall_left   = 0;

  first_match_flow_rule_classifier u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [31:0] net_mask(input logic [5:0] plen);
    if (plen == 6'd0) return '0;
    if (plen >= 6'd32) return '1;
    return 32'hFFFF_FFFF << (32 - plen);
  endfunction

  function automatic bit endpoint_pass(input logic [63:0] ep, input logic [5:0] plen,
                                       input logic port_en, input logic addr_en,
                                       input logic [31:0] addr, input logic [15:0] port,
                                       input logic addr_ok);
    logic [31:0] m;
    m = net_mask(plen);
    if (port_en && (port < ep[47:32] || port > ep[63:48])) return 1'b0;
    if (addr_en && (!addr_ok || ((ep[31:0] ^ addr) & m) != '0)) return 1'b0;
    return 1'b1;
  endfunction

  // Apply one request to the rule store copy and return the result it yields
  function automatic fmrc_out_t classify_request(input fmrc_in_t r);
    fmrc_out_t   res;
    int          rule;
    logic [63:0] ctl;
    logic [1:0]  tgt;
    logic        pair_checked;
    if (r.cmd == CMD_WRITE) begin
      if (r.role < NUM_ROLES && r.word_select != WSEL_BAD) begin
        rule = r.role * RULES_PER_ROLE + r.rule_slot;
        rule_mem[rule*RULE_WORDS + r.word_select]  = r.write_data;
        word_seen[rule*RULE_WORDS + r.word_select] = 1'b1;
        if (r.word_select == WSEL_CTL) begin
          rule_on[rule] = r.write_data[CTL_VALID];
        end
      end
      return WRITE_ACK;
    end
    res = NO_MATCH;
    if (r.role >= NUM_ROLES) return res;
    pair_checked = (r.role == ROLE_TCP_ACTIVE || r.role == ROLE_UDP_PEER) &&
                   r.second_kind != KIND_NONE;
    for (int s = 0; s < RULES_PER_ROLE; s++) begin
      rule = r.role * RULES_PER_ROLE + s;
      ctl  = rule_mem[rule*RULE_WORDS + WSEL_CTL];
      tgt  = ctl[25:24];
      if (rule_on[rule] &&
          endpoint_pass(rule_mem[rule*RULE_WORDS + WSEL_EP1], ctl[5:0], ctl[CTL_PORT1_EN],
                        ctl[CTL_PFX1_EN], r.first_addr, r.first_port, r.first_addr_ok) &&
          (!ctl[CTL_USE2] || !pair_checked ||
           endpoint_pass(rule_mem[rule*RULE_WORDS + WSEL_EP2], ctl[13:8], ctl[CTL_PORT2_EN],
                         ctl[CTL_PFX2_EN], r.second_addr, r.second_port,
                         r.second_kind == KIND_OK)) &&
          (tgt == TR_OS || tgt == TR_ULP || tgt == r.own_transport)) begin
        res.chosen_transport = tgt;
        res.matched          = 1'b1;
        res.matched_slot     = 5'(s);
        return res;
      end
    end
    return res;
  endfunction

  function automatic fmrc_in_t random_noise();
    logic [191:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return bits[$bits(fmrc_in_t)-1:0];
  endfunction

  function automatic fmrc_in_t rule_write(input logic [2:0] role, input logic [4:0] slot,
                                          input logic [1:0] wsel, input logic [63:0] data);
    fmrc_in_t req;
    req             = '0;
    req.cmd         = CMD_WRITE;
    req.role        = role;
    req.rule_slot   = slot;
    req.word_select = wsel;
    req.write_data  = data;
    return req;
  endfunction

  function automatic fmrc_in_t probe(input logic [2:0] role, input logic [1:0] my_tr,
                                     input logic [31:0] a1, input logic [15:0] p1,
                                     input logic ok1, input logic [1:0] kind2,
                                     input logic [31:0] a2, input logic [15:0] p2);
    fmrc_in_t req;
    req               = '0;
    req.cmd           = CMD_LOOKUP;
    req.role          = role;
    req.own_transport = my_tr;
    req.first_addr    = a1;
    req.first_port    = p1;
    req.first_addr_ok = ok1;
    req.second_kind   = kind2;
    req.second_addr   = a2;
    req.second_port   = p2;
    return req;
  endfunction

  function automatic logic [5:0] random_plen();
    if ($urandom_range(0, 9) == 0) return 6'($urandom_range(33, 63));
    return 6'($urandom_range(0, 32));
  endfunction

  function automatic fmrc_in_t random_rule_write(input logic [2:0] role, input logic [4:0] slot,
                                                 input logic [1:0] wsel);
    fmrc_in_t    req;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [63:0] data;
    req = random_noise();
    lo  = 16'($urandom);
    hi  = 16'($urandom);
    if (wsel == WSEL_CTL) begin
      data            = {$urandom, $urandom};
      data[5:0]       = random_plen();
      data[13:8]      = random_plen();
      data[CTL_VALID] = ($urandom_range(0, 4) != 0);
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          lo = '0;
          hi = '1;
        end
        1: hi = (int'(lo) + 2000 > 65535) ? 16'hFFFF : lo + 16'($urandom_range(0, 2000));
        2: hi = lo;
        default: ;
      endcase
      data = {hi, lo, 32'($urandom)};
    end
    req.cmd         = CMD_WRITE;
    req.role        = role;
    req.rule_slot   = slot;
    req.word_select = wsel;
    req.write_data  = data;
    return req;
  endfunction

  function automatic logic [15:0] port_within(input logic [63:0] ep);
    if (ep[47:32] <= ep[63:48] && $urandom_range(0, 7) != 0) begin
      return ep[47:32] + 16'($urandom_range(0, int'(ep[63:48] - ep[47:32])));
    end
    return 16'($urandom);
  endfunction

  // Lookup shaped to pass the checks of one valid rule, with random slack
  function automatic fmrc_in_t aimed_lookup(input logic [2:0] role, input int slot);
    fmrc_in_t    req;
    int          rule;
    logic [63:0] ctl;
    logic [31:0] m;
    req  = random_noise();
    rule = role * RULES_PER_ROLE + slot;
    ctl  = rule_mem[rule*RULE_WORDS + WSEL_CTL];
    req.cmd           = CMD_LOOKUP;
    req.role          = role;
    m                 = net_mask(ctl[5:0]);
    req.first_addr    = (rule_mem[rule*RULE_WORDS + WSEL_EP1][31:0] & m) | (req.first_addr & ~m);
    req.first_port    = port_within(rule_mem[rule*RULE_WORDS + WSEL_EP1]);
    req.first_addr_ok = ($urandom_range(0, 9) != 0);
    req.second_kind   = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : KIND_OK;
    m                 = net_mask(ctl[13:8]);
    req.second_addr   = (rule_mem[rule*RULE_WORDS + WSEL_EP2][31:0] & m) |
                        (req.second_addr & ~m);
    req.second_port   = port_within(rule_mem[rule*RULE_WORDS + WSEL_EP2]);
    if ($urandom_range(0, 1) != 0) req.own_transport = ctl[25:24];
    return req;
  endfunction

  task automatic send_request(input fmrc_in_t req);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(classify_request(req));
    if (req.cmd == CMD_LOOKUP || (req.role < NUM_ROLES && req.word_select != WSEL_BAD)) begin
      useful_items++;
    end
  endtask

  task automatic wait_results_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result side: check each accepted result, then draw the next stall
  always @(posedge clk) begin : result_check
    fmrc_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("unexpected result: tr=%0d m=%0d slot=%0d", out_data.chosen_transport,
                     out_data.matched, out_data.matched_slot);
          end
        end else begin
          want = pending_results.pop_front();
          if (out_data.chosen_transport !== want.chosen_transport ||
              out_data.matched !== want.matched ||
              out_data.matched_slot !== want.matched_slot) begin
            error_count++;
            if (error_count <= 10) begin
              $display("mismatch: expected tr=%0d m=%0d slot=%0d, got tr=%0d m=%0d slot=%0d",
                       want.chosen_transport, want.matched, want.matched_slot,
                       out_data.chosen_transport, out_data.matched, out_data.matched_slot);
            end
          end
        end
        stall_left = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin : stimulus
    fmrc_in_t   req;
    step_t      row;
    logic [2:0] role;
    logic [4:0] slot;
    logic [1:0] wsel;
    int         pick;
    int         next_phase;
    int         next_drain;
    int         open_slots[$];

    // Empty lists, bad role, then one tcp server rule with port range and /8 prefix
    plan.push_back('{probe(ROLE_TCP_SRV, TR_OTHER, 32'h0A01_0203, 16'd150, 1'b1, KIND_NONE,
                           '0, '0), 1'b1, NO_MATCH});
    plan.push_back('{probe(ROLE_MAX_CODE, TR_OTHER, '0, '0, 1'b1, KIND_NONE, '0, '0),
                     1'b1, NO_MATCH});
    plan.push_back('{rule_write(ROLE_TCP_SRV, 5'd0, WSEL_EP1, {16'd200, 16'd100, 32'h0A00_0000}),
                     1'b1, WRITE_ACK});
    plan.push_back('{rule_write(ROLE_TCP_SRV, 5'd0, WSEL_EP2, {16'hFFFF, 16'h0000, 32'h0}),
                     1'b1, WRITE_ACK});
    plan.push_back('{rule_write(ROLE_TCP_SRV, 5'd0, WSEL_CTL, 64'h0000_0001_0003_0008),
                     1'b1, WRITE_ACK});
    plan.push_back('{probe(ROLE_TCP_SRV, TR_OTHER, 32'h0A01_0203, 16'd150, 1'b1, KIND_NONE,
                           '0, '0), 1'b1, '{TR_OS, 1'b1, 5'd0}});
    plan.push_back('{probe(ROLE_TCP_SRV, TR_OTHER, 32'h0A01_0203, 16'd201, 1'b1, KIND_NONE,
                           '0, '0), 1'b1, NO_MATCH});
    plan.push_back('{probe(ROLE_TCP_SRV, TR_DEFAULT, 32'h0AFF_FFFF, 16'd100, 1'b1, KIND_NONE,
                           '0, '0), 1'b0, '0});
    plan.push_back('{probe(ROLE_TCP_SRV, TR_OTHER, 32'h0A01_0203, 16'd150, 1'b0, KIND_NONE,
                           '0, '0), 1'b1, NO_MATCH});
    // Last tcp client slot: full port range, /0 first prefix, second prefix length 40
    plan.push_back('{rule_write(ROLE_TCP_ACTIVE, 5'd31, WSEL_EP1,
                                {16'hFFFF, 16'h0000, 32'hFFFF_FFFF}), 1'b1, WRITE_ACK});
    plan.push_back('{rule_write(ROLE_TCP_ACTIVE, 5'd31, WSEL_EP2, {16'd53, 16'd53, 32'hC0A8_0000}),
                     1'b1, WRITE_ACK});
    plan.push_back('{rule_write(ROLE_TCP_ACTIVE, 5'd31, WSEL_CTL, 64'h0000_0001_031F_2800),
                     1'b1, WRITE_ACK});
    plan.push_back('{probe(ROLE_TCP_ACTIVE, TR_OTHER, 32'h1234_5678, 16'd9, 1'b1, KIND_OK,
                           32'hC0A8_0000, 16'd53), 1'b1, '{TR_OTHER, 1'b1, 5'd31}});
    plan.push_back('{probe(ROLE_TCP_ACTIVE, TR_OTHER, 32'h1234_5678, 16'd9, 1'b1, KIND_OK,
                           32'hC0A8_0001, 16'd53), 1'b1, NO_MATCH});
    plan.push_back('{probe(ROLE_TCP_ACTIVE, TR_OTHER, 32'h1234_5678, 16'd9, 1'b1, KIND_BROKEN,
                           32'hC0A8_0000, 16'd53), 1'b1, NO_MATCH});
    plan.push_back('{probe(ROLE_TCP_ACTIVE, TR_OTHER, 32'h1234_5678, 16'd9, 1'b1, KIND_NONE,
                           '0, '0), 1'b1, '{TR_OTHER, 1'b1, 5'd31}});
    plan.push_back('{probe(ROLE_TCP_ACTIVE, TR_OTHER, 32'h1234_5678, 16'd9, 1'b1, KIND_SPARE,
                           32'hC0A8_0000, 16'd53), 1'b1, NO_MATCH});
    plan.push_back('{probe(ROLE_TCP_ACTIVE, TR_DEFAULT, 32'h1234_5678, 16'd9, 1'b1, KIND_NONE,
                           '0, '0), 1'b1, NO_MATCH});
    // Ignored writes, then the tcp server rule must still hold
    plan.push_back('{rule_write(ROLE_MAX_CODE, 5'd0, WSEL_CTL, '0), 1'b1, WRITE_ACK});
    plan.push_back('{rule_write(ROLE_TCP_SRV, 5'd0, WSEL_BAD, '0), 1'b1, WRITE_ACK});
    plan.push_back('{probe(ROLE_TCP_SRV, TR_OTHER, 32'h0A01_0203, 16'd200, 1'b1, KIND_NONE,
                           '0, '0), 1'b0, '0});
    // Clear the valid bit
    plan.push_back('{rule_write(ROLE_TCP_SRV, 5'd0, WSEL_CTL, 64'h0000_0000_0003_0008),
                     1'b1, WRITE_ACK});
    plan.push_back('{probe(ROLE_TCP_SRV, TR_OTHER, 32'h0A01_0203, 16'd150, 1'b1, KIND_NONE,
                           '0, '0), 1'b1, NO_MATCH});
    plan.push_back('{probe(ROLE_TCP_ACTIVE, TR_OTHER, '1, '1, 1'b1, KIND_OK, '1, '1), 1'b0, '0});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      row = plan[i];
      send_request(row.req);
      // Hold the typed-in value in place of the prediction
      if (row.typed) pending_results[pending_results.size()-1] = row.want;
    end
    wait_results_idle();

    next_phase = useful_items + 100;
    next_drain = useful_items + 300;
    while (useful_items < ITEM_TARGET) begin
      if (useful_items >= next_phase) begin
        idle_on    = ($urandom_range(0, 3) != 0);
        next_phase = useful_items + 100;
      end
      if (useful_items >= next_drain) begin
        wait_results_idle();
        next_drain = useful_items + 300;
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        req     = random_noise();
        req.cmd = CMD_WRITE;
        if ($urandom_range(0, 1) != 0) begin
          req.role = 3'($urandom_range(NUM_ROLES, ROLE_MAX_CODE));
        end else begin
          req.word_select = WSEL_BAD;
        end
        send_request(req);
      end else if (pick < 38) begin
        role = 3'($urandom_range(0, NUM_ROLES - 1));
        slot = 5'($urandom_range(0, RULES_PER_ROLE - 1));
        wsel = 2'($urandom_range(0, 2));
        req  = random_rule_write(role, slot, wsel);
        // Fill both endpoint words before a rule goes valid
        if (wsel == WSEL_CTL && req.write_data[CTL_VALID]) begin
          if (!word_seen[(role*RULES_PER_ROLE + slot)*RULE_WORDS + WSEL_EP1]) begin
            send_request(random_rule_write(role, slot, WSEL_EP1));
          end
          if (!word_seen[(role*RULES_PER_ROLE + slot)*RULE_WORDS + WSEL_EP2]) begin
            send_request(random_rule_write(role, slot, WSEL_EP2));
          end
        end
        send_request(req);
      end else begin
        role = 3'($urandom_range(0, NUM_ROLES - 1));
        open_slots.delete();
        for (int s = 0; s < RULES_PER_ROLE; s++) begin
          if (rule_on[role*RULES_PER_ROLE + s]) open_slots.push_back(s);
        end
        if (pick < 46 || open_slots.size() == 0) begin
          req      = random_noise();
          req.cmd  = CMD_LOOKUP;
          req.role = (pick < 42) ? role : 3'($urandom_range(0, ROLE_MAX_CODE));
        end else begin
          req = aimed_lookup(role, open_slots[$urandom_range(0, open_slots.size() - 1)]);
        end
        send_request(req);
      end
    end

    wait_results_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/fmrc_pkg.sv
rtl/core/fmrc_rule_store.sv
rtl/core/fmrc_match_unit.sv
rtl/core/first_match_flow_rule_classifier.sv
tb/sv/testbench.sv
